// File: src/assert_macros.svh
// Assertion helper macros used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

// File: src/plcs_pkg.sv
// ----------------------------------------------------------------------------
// plcs_pkg
// Types and constants of the permutation LCS unit.
// ----------------------------------------------------------------------------
package plcs_pkg;
   localparam int PERM_SIZE = 1024;
   localparam int SEQ_SIZE  = 4096;
   localparam int PW = $clog2(PERM_SIZE + 1); // position / value width
   localparam int TW = $clog2(PERM_SIZE);     // tails index width
   localparam int KW = $clog2(SEQ_SIZE);      // kept index width
   localparam int CW = $clog2(SEQ_SIZE + 1);  // kept count width

   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_SEQ    = 2'd1;
   localparam logic [1:0] ACT_FINISH = 2'd2;
   localparam logic [1:0] ACT_READ   = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic [10:0] length;
      logic [10:0] element;
      logic        last;
      logic        overflow;
   } rsp_type;

   // Classified command handed from the front part to the back part.
   typedef struct packed {
      logic [1:0]    action;
      logic          valid_val; // value in 1..PERM_SIZE
      logic [PW-1:0] value;
   } cmd_type;
endpackage

// File: src/plcs_front.sv
// ----------------------------------------------------------------------------
// plcs_front
// Accepts items, classifies the value and queues commands for the back part.
// ----------------------------------------------------------------------------
module plcs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  plcs_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_take,
   output plcs_pkg::cmd_type cmd_data
);
   import plcs_pkg::*;

   cmd_type    q_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   cmd_type    c;
   logic       push, pop;

   assign req_stall = (cnt_ff == 3'd4);
   assign push = req_valid && !req_stall;
   assign pop  = cmd_valid && cmd_take;
   assign cmd_valid = (cnt_ff != 3'd0);
   assign cmd_data  = q_ff[rp_ff];

   always_comb begin
      c.action    = req_data.action;
      c.valid_val = (req_data.value != 16'd0) && (req_data.value <= 16'(PERM_SIZE));
      c.value     = req_data.value[PW-1:0];
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= c;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop)  rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'b0, push} - {2'b0, pop};
      end
   end
endmodule

// File: src/plcs_back.sv
// ----------------------------------------------------------------------------
// plcs_back
// Sequencer over the stores: map, LIS search, link walk and readout.
// ----------------------------------------------------------------------------
module plcs_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  plcs_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output plcs_pkg::rsp_type rsp_data,
   output logic              busy
);
   import plcs_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_MAPRD, S_MAPWT, S_SRCH_A, S_SRCH_B, S_SRCH_C,
      S_PRED, S_PRED_W, S_FIN_A, S_FIN_B, S_FIN_C, S_RD_A, S_RD_B, S_OUT
   } state_type;

   logic [PW-1:0] pmap [PERM_SIZE+1];
   logic [PW-1:0] kpos [SEQ_SIZE];
   logic [PW-1:0] kval [SEQ_SIZE];
   logic [CW-1:0] plink [SEQ_SIZE];
   logic [KW-1:0] tails [PERM_SIZE];
   logic [PW-1:0] rstore [PERM_SIZE];

   state_type     state_ff;
   logic [PW-1:0] clr_ff, load_cnt_ff, tlen_ff, rcount_ff, rptr_ff;
   logic [CW-1:0] kcnt_ff;
   logic          ovf_ff;
   cmd_type       cmd_ff;
   logic [PW-1:0] pos_ff, lo_ff, hi_ff, md_ff, n_ff;
   logic [PW-1:0] pmap_rd_ff, kpos_rd_ff, kval_rd_ff, rstore_rd_ff;
   logic [KW-1:0] tails_rd_ff;
   logic [CW-1:0] plink_rd_ff;
   rsp_type       rsp_ff;
   logic          rsp_v_ff;
   logic          rsp_free, rsp_load, rsp_v_in;

   assign cmd_take  = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;
   assign busy      = (state_ff != S_IDLE) || rsp_v_ff;

   // The output register takes a new item once the previous one has gone.
   assign rsp_free = !rsp_v_ff || !rsp_stall;
   assign rsp_load = rsp_free &&
                     ((state_ff == S_RD_A) || (state_ff == S_RD_B) || (state_ff == S_OUT));
   assign rsp_v_in = rsp_load || (rsp_v_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; load_cnt_ff <= '0; tlen_ff <= '0;
         rcount_ff <= '0; rptr_ff <= '0; kcnt_ff <= '0; ovf_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= rsp_v_in;
         unique case (state_ff)
            S_CLEAR: begin
               // Position map is cleared one entry at a time after reset.
               pmap[clr_ff] <= '0;
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == PW'(PERM_SIZE)) state_ff <= S_IDLE;
            end
            S_IDLE: if (cmd_valid) begin
               cmd_ff <= cmd_data;
               unique case (cmd_data.action)
                  ACT_LOAD: begin
                     if (load_cnt_ff == PW'(PERM_SIZE)) ovf_ff <= 1'b1;
                     else begin
                        load_cnt_ff <= load_cnt_ff + 1'b1;
                        if (cmd_data.valid_val)
                           pmap[cmd_data.value] <= load_cnt_ff + 1'b1;
                     end
                  end
                  ACT_SEQ: if (cmd_data.valid_val && cmd_data.value <= load_cnt_ff) begin
                     pmap_rd_ff <= pmap[cmd_data.value];
                     state_ff <= S_MAPWT;
                  end
                  ACT_FINISH: begin
                     rcount_ff <= tlen_ff; rptr_ff <= '0; n_ff <= tlen_ff;
                     if (tlen_ff == '0) state_ff <= S_OUT;
                     else begin
                        tails_rd_ff <= tails[TW'(tlen_ff - 1'b1)];
                        state_ff <= S_FIN_A;
                     end
                  end
                  default: begin
                     if (rptr_ff < rcount_ff) begin
                        rstore_rd_ff <= rstore[TW'(rptr_ff)];
                        state_ff <= S_RD_A;
                     end else state_ff <= S_OUT;
                  end
               endcase
            end
            S_MAPWT: begin
               if (pmap_rd_ff == '0) state_ff <= S_IDLE;
               else if (kcnt_ff == CW'(SEQ_SIZE)) begin
                  ovf_ff <= 1'b1; state_ff <= S_IDLE;
               end else begin
                  pos_ff <= pmap_rd_ff; lo_ff <= '0; hi_ff <= tlen_ff;
                  state_ff <= S_SRCH_A;
               end
            end
            S_SRCH_A: begin
               if (lo_ff < hi_ff) begin
                  md_ff <= PW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
                  tails_rd_ff <= tails[TW'(PW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1))];
                  state_ff <= S_SRCH_B;
               end else if (lo_ff >= PW'(PERM_SIZE)) begin
                  ovf_ff <= 1'b1; state_ff <= S_IDLE;
               end else begin
                  if (lo_ff != '0) tails_rd_ff <= tails[TW'(lo_ff - 1'b1)];
                  state_ff <= S_PRED;
               end
            end
            S_SRCH_B: begin
               kpos_rd_ff <= kpos[tails_rd_ff];
               state_ff <= S_SRCH_C;
            end
            S_SRCH_C: begin
               if (kpos_rd_ff < pos_ff) lo_ff <= md_ff + 1'b1;
               else hi_ff <= md_ff;
               state_ff <= S_SRCH_A;
            end
            S_PRED: begin
               kpos[kcnt_ff[KW-1:0]] <= pos_ff;
               kval[kcnt_ff[KW-1:0]] <= cmd_ff.value;
               plink[kcnt_ff[KW-1:0]] <= (lo_ff != '0) ? ({1'b0, tails_rd_ff} + 1'b1) : '0;
               tails[TW'(lo_ff)] <= kcnt_ff[KW-1:0];
               if (lo_ff == tlen_ff) tlen_ff <= tlen_ff + 1'b1;
               kcnt_ff <= kcnt_ff + 1'b1;
               state_ff <= S_IDLE;
            end
            S_FIN_A: begin
               kval_rd_ff <= kval[tails_rd_ff]; plink_rd_ff <= plink[tails_rd_ff];
               state_ff <= S_FIN_B;
            end
            S_FIN_B: begin
               rstore[TW'(n_ff - 1'b1)] <= kval_rd_ff;
               n_ff <= n_ff - 1'b1;
               if (plink_rd_ff == '0 || plink_rd_ff > CW'(SEQ_SIZE) || n_ff == PW'(1))
                  state_ff <= S_OUT;
               else begin
                  tails_rd_ff <= KW'(plink_rd_ff - 1'b1);
                  state_ff <= S_FIN_A;
               end
            end
            S_RD_A: begin
               rptr_ff <= rptr_ff + 1'b1;
               if (rsp_free) begin
                  rsp_ff.length <= rcount_ff; rsp_ff.element <= rstore_rd_ff;
                  rsp_ff.last <= (rptr_ff + 1'b1 == rcount_ff);
                  rsp_ff.overflow <= ovf_ff;
                  state_ff <= S_IDLE;
               end else state_ff <= S_RD_B;
            end
            S_RD_B: if (rsp_free) begin
               rsp_ff.length <= rcount_ff; rsp_ff.element <= rstore_rd_ff;
               rsp_ff.last <= (rptr_ff == rcount_ff);
               rsp_ff.overflow <= ovf_ff;
               state_ff <= S_IDLE;
            end
            S_OUT: if (rsp_free) begin
               rsp_ff.length <= rcount_ff; rsp_ff.element <= '0;
               rsp_ff.last <= (cmd_ff.action == ACT_FINISH) ? (rcount_ff == '0) : 1'b1;
               rsp_ff.overflow <= ovf_ff;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: src/permutation_lcs_via_lis_unit.sv
// Sequence items run a binary search over the tails (each step goes through S_SRCH_A,
// S_SRCH_B and S_SRCH_C); finish walks the links back through S_FIN_A and S_FIN_B.
// The back sequencer handles one item at a time; a four-entry queue buffers items.
// Reset: synchronous; afterwards a pass clears every entry of the position map,
// during which items queue but are not executed.
// ----------------------------------------------------------------------------
// permutation_lcs_via_lis_unit
// LCS of a permutation and a sequence via patience LIS with reconstruction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module permutation_lcs_via_lis_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  plcs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output plcs_pkg::rsp_type rsp_data
);
   import plcs_pkg::*;

   logic    cmd_valid, cmd_take, busy;
   cmd_type cmd_data;

   plcs_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .cmd_valid, .cmd_take, .cmd_data
   );

   plcs_back u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd_data,
      .rsp_valid, .rsp_stall, .rsp_data, .busy
   );

   `ASSERT_IMPLY(a_take_needs_cmd, clock, reset, cmd_take, cmd_valid)
   `ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `ASSERT_IMPLY(a_busy_on_rsp, clock, reset, rsp_valid, busy)
endmodule

// File: tb/permutation_lcs_via_lis_unit_tb.sv
// ----------------------------------------------------------------------------
// permutation_lcs_via_lis_unit_tb
// Drives load, sequence, finish and read items into the permutation LCS unit
// and checks every result against a behavioural model of the LIS search.
// ----------------------------------------------------------------------------
module permutation_lcs_via_lis_unit_tb;
   import plcs_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int      n_errors = 0;
   int      n_checked = 0;
   int      n_sent = 0;
   bit      quiet = 1'b0;
   rsp_type pending_rsps[$];

   // Model state.
   int unsigned pos_map[PERM_SIZE + 1];
   int unsigned n_loaded, n_kept, n_tails, rd_ptr, lcs_len;
   int unsigned kept_pos[SEQ_SIZE];
   int unsigned kept_val[SEQ_SIZE];
   int unsigned pred_link[SEQ_SIZE];
   int unsigned tail_idx[PERM_SIZE];
   int unsigned lcs_vals[PERM_SIZE];
   bit          ovf;

   permutation_lcs_via_lis_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   initial begin
      #50000000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic model_clear();
      foreach (pos_map[i]) pos_map[i] = 0;
      n_loaded = 0; n_kept = 0; n_tails = 0; rd_ptr = 0; lcs_len = 0; ovf = 1'b0;
   endtask

   task automatic predict_lcs(input req_type r);
      int unsigned v, p, lo, hi, md, cur, n, lk;
      rsp_type e;
      v = 32'(r.value);
      e = '0;
      case (r.action)
         ACT_LOAD: begin
            if (n_loaded >= PERM_SIZE) ovf = 1'b1;
            else begin
               n_loaded++;
               if (v != 0 && v <= PERM_SIZE) pos_map[v] = n_loaded;
            end
            return;
         end
         ACT_SEQ: begin
            if (v == 0 || v > n_loaded || v > PERM_SIZE) return;
            p = pos_map[v];
            if (p == 0) return;
            if (n_kept >= SEQ_SIZE) begin
               ovf = 1'b1;
               return;
            end
            lo = 0; hi = n_tails;
            while (lo < hi) begin
               md = (lo + hi) / 2;
               if (kept_pos[tail_idx[md]] < p) lo = md + 1;
               else hi = md;
            end
            if (lo >= PERM_SIZE) begin
               ovf = 1'b1;
               return;
            end
            kept_pos[n_kept] = p;
            kept_val[n_kept] = v;
            pred_link[n_kept] = (lo > 0) ? tail_idx[lo - 1] + 1 : 0;
            tail_idx[lo] = n_kept;
            if (lo == n_tails) n_tails++;
            n_kept++;
            return;
         end
         ACT_FINISH: begin
            n = n_tails;
            lcs_len = n;
            rd_ptr = 0;
            if (n != 0) begin
               cur = tail_idx[n - 1];
               while (n > 0) begin
                  n--;
                  lcs_vals[n] = kept_val[cur];
                  lk = pred_link[cur];
                  if (lk == 0 || lk > SEQ_SIZE) break;
                  cur = lk - 1;
               end
            end
            e.last = (lcs_len == 0);
         end
         default: begin
            if (rd_ptr < lcs_len) begin
               e.element = 11'(lcs_vals[rd_ptr]);
               e.last = (rd_ptr + 1 == lcs_len);
               rd_ptr++;
            end else e.last = 1'b1;
         end
      endcase
      e.length = 11'(lcs_len);
      e.overflow = ovf;
      pending_rsps.insert(pending_rsps.size(), e);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      n_errors++;
      $display("mismatch on result %0d: %s got %0d expected %0d", n_checked, what, got,
         want);
   endtask

   // Results are compared as they are accepted.
   always @(posedge clock) begin
      if (!reset) begin
         rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 33);
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsps.size() == 0) report_mismatch("unexpected result", 1, 0);
            else begin
               rsp_type e;
               e = pending_rsps.pop_front();
               if (rsp_data.length != e.length)
                  report_mismatch("length", int'(rsp_data.length), int'(e.length));
               if (rsp_data.element != e.element)
                  report_mismatch("element", int'(rsp_data.element), int'(e.element));
               if (rsp_data.last != e.last)
                  report_mismatch("last", int'(rsp_data.last), int'(e.last));
               if (rsp_data.overflow != e.overflow)
                  report_mismatch("overflow", int'(rsp_data.overflow), int'(e.overflow));
            end
            n_checked++;
         end
      end
   end

   task automatic send_item(input logic [1:0] act, input logic [15:0] val);
      req_type r;
      r.action = act;
      r.value = val;
      while (!quiet && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_lcs(r);
      n_sent++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic test_directed();
      send_item(ACT_READ, 16'hFFFF);   // read before any finish
      send_item(ACT_FINISH, 16'd0);    // finish with nothing kept
      send_item(ACT_LOAD, 16'd3);
      send_item(ACT_LOAD, 16'd0);      // takes a position, no map write
      send_item(ACT_LOAD, 16'hFFFF);   // above range
      send_item(ACT_LOAD, 16'd1);
      send_item(ACT_LOAD, 16'd2);
      send_item(ACT_LOAD, 16'd3);      // repeated value overwrites
      send_item(ACT_SEQ, 16'd0);
      send_item(ACT_SEQ, 16'hFFFF);
      send_item(ACT_SEQ, 16'd4);       // absent
      send_item(ACT_SEQ, 16'd1);
      send_item(ACT_SEQ, 16'd2);
      send_item(ACT_SEQ, 16'd3);
      send_item(ACT_SEQ, 16'd2);
      send_item(ACT_FINISH, 16'hFFFF);
      repeat (4) send_item(ACT_READ, 16'($urandom));
      send_item(ACT_FINISH, 16'd0);    // repeated finish rewinds
      send_item(ACT_READ, 16'd0);
      wait_drain();
   endtask

   // Random rounds: a permutation, a sequence with random items mixed in, a finish and reads.
   task automatic test_random_rounds();
      int sz, k;
      int perm[$];
      while (n_sent < 370) begin
         sz = int'($urandom_range(1, 24));
         perm.delete();
         for (int i = 1; i <= sz; i++) perm = {perm, i};
         perm.shuffle();
         foreach (perm[i]) send_item(ACT_LOAD, 16'(perm[i]));
         k = int'($urandom_range(1, 30));
         repeat (k) begin
            if ($urandom_range(9) == 0) send_item(2'($urandom), 16'($urandom));
            else send_item(ACT_SEQ, 16'($urandom_range(0, n_loaded + 2)));
         end
         send_item(ACT_FINISH, 16'($urandom));
         repeat ($urandom_range(0, 30)) send_item(ACT_READ, 16'($urandom));
         if ($urandom_range(3) == 0) wait_drain();
      end
      wait_drain();
   endtask

   // A short round sent with no idling on either side, then reads.
   task automatic test_back_to_back();
      quiet = 1'b1;
      repeat (12) send_item(ACT_LOAD, 16'($urandom_range(1, 64)));
      repeat (16) send_item(ACT_SEQ, 16'($urandom_range(0, n_loaded + 2)));
      send_item(ACT_FINISH, 16'd0);
      repeat (10) send_item(ACT_READ, 16'($urandom));
      quiet = 1'b0;
      wait_drain();
   endtask

   initial begin
      model_clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_rounds();
      test_back_to_back();
      $display("Sent %0d items and checked %0d results: directed cases, random rounds,",
         n_sent, n_checked);
      $display("and a round sent back to back with no idling.");
      if (n_errors == 0 && pending_rsps.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
